>>> rtl/core/qam_pkg.sv
// Shared types, register indexes, reset values and the microprogram of the attitude mixer.
`timescale 1ns / 1ps
`default_nettype none

package qam_pkg;

    // Fixed field widths
    localparam int CFG_W = 19;
    localparam int ALT_W = 24;
    localparam int SPD_W = 21;
    localparam int GIM_W = 14;

    // Configuration register indexes
    localparam logic [2:0] CFG_HOVER_THRUST  = 3'd0;
    localparam logic [2:0] CFG_ALTITUDE_BIAS = 3'd1;
    localparam logic [2:0] CFG_VERTICAL_GAIN = 3'd2;
    localparam logic [2:0] CFG_ROLL_GAIN     = 3'd3;
    localparam logic [2:0] CFG_PITCH_GAIN    = 3'd4;
    localparam logic [2:0] CFG_ROLL_OFFSET   = 3'd5;
    localparam logic [2:0] CFG_PITCH_NUDGE   = 3'd6;
    localparam logic [2:0] CFG_YAW_NUDGE     = 3'd7;

    // Register reset values
    localparam logic [18:0]        RST_HOVER_THRUST  = 19'd280576;
    localparam logic signed [13:0] RST_ALTITUDE_BIAS = 14'sd2458;
    localparam logic [17:0]        RST_VERTICAL_GAIN = 18'd12288;
    localparam logic [17:0]        RST_ROLL_GAIN     = 18'd204800;
    localparam logic [17:0]        RST_PITCH_GAIN    = 18'd122880;
    localparam logic signed [14:0] RST_ROLL_OFFSET   = 15'sd6434;
    localparam logic [14:0]        RST_PITCH_NUDGE   = 15'd8192;
    localparam logic [14:0]        RST_YAW_NUDGE     = 15'd5325;

    // Pilot command codes (the remaining codes mean no command)
    localparam logic [1:0] CMD_POS = 2'b01;
    localparam logic [1:0] CMD_NEG = 2'b11;

    // Micro-operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_MUL  = 3'd1;
    localparam logic [2:0] OP_GOAL = 3'd2;
    localparam logic [2:0] OP_PREP = 3'd3;
    localparam logic [2:0] OP_SUM  = 3'd4;
    localparam logic [2:0] OP_OUT  = 3'd5;

    // Multiplier operand A sources
    localparam logic [2:0] A_STEP  = 3'd0;
    localparam logic [2:0] A_RGAIN = 3'd1;
    localparam logic [2:0] A_PGAIN = 3'd2;
    localparam logic [2:0] A_D     = 3'd3;
    localparam logic [2:0] A_VGAIN = 3'd4;
    localparam logic [2:0] A_KR    = 3'd5;
    localparam logic [2:0] A_KP    = 3'd6;

    // Multiplier operand B sources
    localparam logic [2:0] B_STEPS = 3'd0;
    localparam logic [2:0] B_CR    = 3'd1;
    localparam logic [2:0] B_CP    = 3'd2;
    localparam logic [2:0] B_D     = 3'd3;
    localparam logic [2:0] B_T     = 3'd4;
    localparam logic [2:0] B_RRATE = 3'd5;
    localparam logic [2:0] B_PRATE = 3'd6;

    // Product destinations
    localparam logic [2:0] D_T  = 3'd0;
    localparam logic [2:0] D_RP = 3'd1;
    localparam logic [2:0] D_PP = 3'd2;
    localparam logic [2:0] D_GR = 3'd3;
    localparam logic [2:0] D_GP = 3'd4;

    // Jump conditions
    localparam logic [1:0] JC_NEVER       = 2'd0;
    localparam logic [1:0] JC_NO_ITEM     = 2'd1;
    localparam logic [1:0] JC_OUT_BLOCKED = 2'd2;
    localparam logic [1:0] JC_ALWAYS      = 2'd3;

    // Step addresses that are jump targets
    localparam logic [3:0] UPC_IDLE = 4'd0;
    localparam logic [3:0] UPC_SUM  = 4'd11;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] dst;
        logic       shr;
        logic [1:0] jc;
        logic [3:0] tgt;
    } t_uop;

    // Microprogram: one control word per step
    function automatic t_uop ucode(input logic [3:0] upc);
        t_uop w;
        case (upc)
            4'd0:  w = '{OP_NOP,  A_STEP,  B_STEPS, D_T,  1'b0, JC_NO_ITEM,     UPC_IDLE};
            4'd1:  w = '{OP_MUL,  A_STEP,  B_STEPS, D_T,  1'b0, JC_NEVER,       UPC_IDLE};
            4'd2:  w = '{OP_GOAL, A_STEP,  B_STEPS, D_T,  1'b0, JC_NEVER,       UPC_IDLE};
            4'd3:  w = '{OP_PREP, A_STEP,  B_STEPS, D_T,  1'b0, JC_NEVER,       UPC_IDLE};
            4'd4:  w = '{OP_MUL,  A_RGAIN, B_CR,    D_RP, 1'b1, JC_NEVER,       UPC_IDLE};
            4'd5:  w = '{OP_MUL,  A_PGAIN, B_CP,    D_PP, 1'b1, JC_NEVER,       UPC_IDLE};
            4'd6:  w = '{OP_MUL,  A_D,     B_D,     D_T,  1'b1, JC_NEVER,       UPC_IDLE};
            4'd7:  w = '{OP_MUL,  A_D,     B_T,     D_T,  1'b1, JC_NEVER,       UPC_IDLE};
            4'd8:  w = '{OP_MUL,  A_VGAIN, B_T,     D_T,  1'b1, JC_NEVER,       UPC_IDLE};
            4'd9:  w = '{OP_MUL,  A_KR,    B_RRATE, D_GR, 1'b1, JC_NEVER,       UPC_IDLE};
            4'd10: w = '{OP_MUL,  A_KP,    B_PRATE, D_GP, 1'b1, JC_NEVER,       UPC_IDLE};
            4'd11: w = '{OP_SUM,  A_STEP,  B_STEPS, D_T,  1'b0, JC_OUT_BLOCKED, UPC_SUM};
            4'd12: w = '{OP_OUT,  A_STEP,  B_STEPS, D_T,  1'b0, JC_ALWAYS,      UPC_IDLE};
            default: w = '{OP_NOP, A_STEP, B_STEPS, D_T,  1'b0, JC_ALWAYS,      UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/quadrotor_attitude_mixer_top.sv
// Quadrotor attitude stabiliser and X-frame motor mixer, microcoded around one multiplier.
//
// Usage: one input item per control tick on the valid/ready input channel carries the
// attitude angles, body rates, altitude, elapsed seconds and pilot commands. One result
// item leaves on the valid/ready output channel: four propeller speeds, two gimbal
// positions and two LED bits. Eight configuration registers are written through the
// write port (i_cfg_we, i_cfg_index, i_cfg_data); the user must write them only while the block is idle;
// the block itself does not enforce this. Timing: a 13-step microprogram drives a single
// signed multiplier; steps 1 to 12 run after the item is taken, and the result is registered
// at step 12. The eight multiplications through the one multiplier set the length of the
// sequence. Input ready is high only while the sequencer sits at its idle step.
// A finished result waits in the output registers; the next item is accepted meanwhile.
// If the receiver still holds the previous result when a new one is due, the sequencer
// waits at its summing step until that result is taken.
// Reset (synchronous, active low) returns the sequencer to idle, drops output valid,
// restores the register defaults and sets the altitude goal to 1.0 m.
`timescale 1ns / 1ps
`default_nettype none

module quadrotor_attitude_mixer_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration port
    input  wire                        i_cfg_we,
    input  wire  [2:0]                 i_cfg_index,
    input  wire  [qam_pkg::CFG_W-1:0]  i_cfg_data,
    // input channel
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  signed [15:0]         i_roll_angle,
    input  wire  signed [15:0]         i_pitch_angle,
    input  wire  signed [23:0]         i_altitude,
    input  wire  signed [15:0]         i_roll_rate,
    input  wire  signed [15:0]         i_pitch_rate,
    input  wire  [15:0]                i_elapsed_seconds,
    input  wire  signed [1:0]          i_pitch_command,
    input  wire  signed [1:0]          i_yaw_command,
    input  wire  signed [1:0]          i_roll_command,
    input  wire  signed [4:0]          i_altitude_steps,
    // output channel
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic signed [20:0]         o_front_left_speed,
    output logic signed [20:0]         o_front_right_speed,
    output logic signed [20:0]         o_rear_left_speed,
    output logic signed [20:0]         o_rear_right_speed,
    output logic signed [13:0]         o_gimbal_roll_position,
    output logic signed [13:0]         o_gimbal_pitch_position,
    output logic                       o_left_led_on,
    output logic                       o_right_led_on
);

    // Datapath widths and fixed-point constants
    localparam int MW     = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
    localparam int PW     = 2 * MW;
    localparam int DW     = 26;
    localparam int SW     = 24;
    localparam int AW     = qam_pkg::ALT_W;
    localparam int OW     = qam_pkg::SPD_W;
    localparam int GW     = qam_pkg::GIM_W;
    localparam int ONE_Q  = 1 << FRAC_BITS;
    localparam int STEP_Q = ((5 << FRAC_BITS) + 50) / 100;
    localparam int KR_Q   = ((115 << FRAC_BITS) + 500) / 1000;
    localparam int KP_Q   = ((1 << FRAC_BITS) + 5) / 10;

    localparam logic signed [MW-1:0] ONE_M   = MW'(ONE_Q);
    localparam logic signed [MW-1:0] NONE_M  = MW'(-ONE_Q);
    localparam logic signed [DW-1:0] ONE_D   = DW'(ONE_Q);
    localparam logic signed [DW-1:0] NONE_D  = DW'(-ONE_Q);
    localparam logic signed [SW-1:0] ONE_S   = SW'(ONE_Q);
    localparam logic signed [MW-1:0] STEP_M  = MW'(STEP_Q);
    localparam logic signed [MW-1:0] KR_M    = MW'(-KR_Q);
    localparam logic signed [MW-1:0] KP_M    = MW'(-KP_Q);
    localparam logic signed [DW-1:0] GMAX_D  = DW'((1 << (AW - 1)) - 1);
    localparam logic signed [DW-1:0] GMIN_D  = DW'(-(1 << (AW - 1)));
    localparam logic signed [SW-1:0] SMAX_S  = SW'((1 << (OW - 1)) - 1);
    localparam logic signed [SW-1:0] SMIN_S  = SW'(-(1 << (OW - 1)));
    localparam logic signed [AW-1:0] GOAL_RST = AW'(ONE_Q);

    // Configuration registers
    logic        [18:0] r_hover;
    logic signed [13:0] r_bias;
    logic        [17:0] r_vgain;
    logic        [17:0] r_rgain;
    logic        [17:0] r_pgain;
    logic signed [14:0] r_roll_off;
    logic        [14:0] r_pnudge;
    logic        [14:0] r_ynudge;

    // Sequencer
    logic [3:0]     r_upc;
    logic [3:0]     n_upc;
    qam_pkg::t_uop  uop;
    logic           jump;
    logic           in_accept;

    // Latched item
    logic signed [15:0]   r_roll;
    logic signed [15:0]   r_pitch;
    logic signed [AW-1:0] r_alt;
    logic signed [15:0]   r_rrate;
    logic signed [15:0]   r_prate;
    logic [1:0]           r_pcmd;
    logic [1:0]           r_ycmd;
    logic [1:0]           r_rcmd;
    logic signed [4:0]    r_steps;
    logic                 r_led;

    // Working registers
    logic signed [AW-1:0] r_goal;
    logic signed [MW-1:0] r_t;
    logic signed [MW-1:0] r_rp;
    logic signed [MW-1:0] r_pp;
    logic signed [GW-1:0] r_gr;
    logic signed [GW-1:0] r_gp;
    logic signed [MW-1:0] r_d;
    logic signed [MW-1:0] r_cr;
    logic signed [MW-1:0] r_cp;
    logic signed [SW-1:0] r_sr;
    logic signed [SW-1:0] r_sp;
    logic signed [SW-1:0] r_sy;
    logic signed [SW-1:0] r_base;

    // Combinational datapath
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [DW-1:0] goal_sum;
    logic signed [AW-1:0] n_goal;
    logic signed [DW-1:0] diff;
    logic signed [MW-1:0] roll_sum;
    logic signed [MW-1:0] pitch_ext;
    logic signed [SW-1:0] rc_term;
    logic signed [SW-1:0] pc_term;
    logic signed [SW-1:0] yc_term;
    logic signed [SW-1:0] mix_fl;
    logic signed [SW-1:0] mix_fr;
    logic signed [SW-1:0] mix_rl;
    logic signed [SW-1:0] mix_rr;

    function automatic logic signed [MW-1:0] clamp_one(input logic signed [MW-1:0] v);
        return (v < NONE_M) ? NONE_M : ((v > ONE_M) ? ONE_M : v);
    endfunction

    function automatic logic signed [OW-1:0] sat_spd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v < SMIN_S) ? SMIN_S : ((v > SMAX_S) ? SMAX_S : v);
        return c[OW-1:0];
    endfunction

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_upc == qam_pkg::UPC_IDLE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hover    <= qam_pkg::RST_HOVER_THRUST;
            r_bias     <= qam_pkg::RST_ALTITUDE_BIAS;
            r_vgain    <= qam_pkg::RST_VERTICAL_GAIN;
            r_rgain    <= qam_pkg::RST_ROLL_GAIN;
            r_pgain    <= qam_pkg::RST_PITCH_GAIN;
            r_roll_off <= qam_pkg::RST_ROLL_OFFSET;
            r_pnudge   <= qam_pkg::RST_PITCH_NUDGE;
            r_ynudge   <= qam_pkg::RST_YAW_NUDGE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qam_pkg::CFG_HOVER_THRUST:  r_hover    <= i_cfg_data[18:0];
                qam_pkg::CFG_ALTITUDE_BIAS: r_bias     <= i_cfg_data[13:0];
                qam_pkg::CFG_VERTICAL_GAIN: r_vgain    <= i_cfg_data[17:0];
                qam_pkg::CFG_ROLL_GAIN:     r_rgain    <= i_cfg_data[17:0];
                qam_pkg::CFG_PITCH_GAIN:    r_pgain    <= i_cfg_data[17:0];
                qam_pkg::CFG_ROLL_OFFSET:   r_roll_off <= i_cfg_data[14:0];
                qam_pkg::CFG_PITCH_NUDGE:   r_pnudge   <= i_cfg_data[14:0];
                qam_pkg::CFG_YAW_NUDGE:     r_ynudge   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Control word fetch and next step
    always_comb begin
        uop = qam_pkg::ucode(r_upc);
        case (uop.jc)
            qam_pkg::JC_NEVER:       jump = 1'b0;
            qam_pkg::JC_NO_ITEM:     jump = !in_accept;
            qam_pkg::JC_OUT_BLOCKED: jump = o_out_valid && !i_out_ready;
            qam_pkg::JC_ALWAYS:      jump = 1'b1;
            default:                 jump = 1'b1;
        endcase
        n_upc = jump ? uop.tgt : r_upc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= qam_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_roll  <= i_roll_angle;
            r_pitch <= i_pitch_angle;
            r_alt   <= i_altitude;
            r_rrate <= i_roll_rate;
            r_prate <= i_pitch_rate;
            r_pcmd  <= i_pitch_command;
            r_ycmd  <= i_yaw_command;
            r_rcmd  <= i_roll_command;
            r_steps <= i_altitude_steps;
            r_led   <= i_elapsed_seconds[0];
        end
    end

    // Shared multiplier operand selection
    always_comb begin
        case (uop.a_sel)
            qam_pkg::A_STEP:  mul_a = STEP_M;
            qam_pkg::A_RGAIN: mul_a = MW'(r_rgain);
            qam_pkg::A_PGAIN: mul_a = MW'(r_pgain);
            qam_pkg::A_D:     mul_a = r_d;
            qam_pkg::A_VGAIN: mul_a = MW'(r_vgain);
            qam_pkg::A_KR:    mul_a = KR_M;
            qam_pkg::A_KP:    mul_a = KP_M;
            default:          mul_a = '0;
        endcase
        case (uop.b_sel)
            qam_pkg::B_STEPS: mul_b = MW'(r_steps);
            qam_pkg::B_CR:    mul_b = r_cr;
            qam_pkg::B_CP:    mul_b = r_cp;
            qam_pkg::B_D:     mul_b = r_d;
            qam_pkg::B_T:     mul_b = r_t;
            qam_pkg::B_RRATE: mul_b = MW'(r_rrate);
            qam_pkg::B_PRATE: mul_b = MW'(r_prate);
            default:          mul_b = '0;
        endcase
    end

    // Product, floor-scaled back to the fixed-point grid where asked
    assign prod    = PW'(mul_a) * PW'(mul_b);
    assign prod_sh = uop.shr ? (prod >>> FRAC_BITS) : prod;

    always_ff @(posedge i_clk) begin
        if (uop.op == qam_pkg::OP_MUL) begin
            case (uop.dst)
                qam_pkg::D_T:  r_t  <= prod_sh[MW-1:0];
                qam_pkg::D_RP: r_rp <= prod_sh[MW-1:0];
                qam_pkg::D_PP: r_pp <= prod_sh[MW-1:0];
                qam_pkg::D_GR: r_gr <= prod_sh[GW-1:0];
                qam_pkg::D_GP: r_gp <= prod_sh[GW-1:0];
                default: ;
            endcase
        end
    end

    // Goal update with saturation to the altitude range
    always_comb begin
        goal_sum = DW'(r_goal) + DW'(r_t);
        if (goal_sum > GMAX_D) begin
            n_goal = GMAX_D[AW-1:0];
        end else if (goal_sum < GMIN_D) begin
            n_goal = GMIN_D[AW-1:0];
        end else begin
            n_goal = goal_sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal <= GOAL_RST;
        end else if (uop.op == qam_pkg::OP_GOAL) begin
            r_goal <= n_goal;
        end
    end

    // Clamped altitude error and attitude terms
    assign diff      = DW'(r_goal) - DW'(r_alt) + DW'(r_bias);
    assign roll_sum  = MW'(r_roll) + MW'(r_roll_off);
    assign pitch_ext = MW'(r_pitch);

    always_ff @(posedge i_clk) begin
        if (uop.op == qam_pkg::OP_PREP) begin
            r_d  <= (diff < NONE_D) ? NONE_M : ((diff > ONE_D) ? ONE_M : diff[MW-1:0]);
            r_cr <= clamp_one(roll_sum);
            r_cp <= clamp_one(pitch_ext);
        end
    end

    // Axis sums and base lift
    always_comb begin
        case (r_rcmd)
            qam_pkg::CMD_POS: rc_term = ONE_S;
            qam_pkg::CMD_NEG: rc_term = -ONE_S;
            default:          rc_term = '0;
        endcase
        case (r_pcmd)
            qam_pkg::CMD_POS: pc_term = SW'(r_pnudge);
            qam_pkg::CMD_NEG: pc_term = -SW'(r_pnudge);
            default:          pc_term = '0;
        endcase
        case (r_ycmd)
            qam_pkg::CMD_POS: yc_term = SW'(r_ynudge);
            qam_pkg::CMD_NEG: yc_term = -SW'(r_ynudge);
            default:          yc_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (uop.op == qam_pkg::OP_SUM) begin
            r_sr   <= SW'(r_rp) + SW'(r_rrate) + rc_term;
            r_sp   <= SW'(r_pp) - SW'(r_prate) + pc_term;
            r_sy   <= yc_term;
            r_base <= SW'(r_hover) + SW'(r_t);
        end
    end

    // X-frame mix; front right and rear left run reversed
    assign mix_fl = r_base - r_sr - r_sp + r_sy;
    assign mix_fr = -(r_base + r_sr - r_sp - r_sy);
    assign mix_rl = -(r_base - r_sr + r_sp - r_sy);
    assign mix_rr = r_base + r_sr + r_sp + r_sy;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (uop.op == qam_pkg::OP_OUT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uop.op == qam_pkg::OP_OUT) begin
            o_front_left_speed      <= sat_spd(mix_fl);
            o_front_right_speed     <= sat_spd(mix_fr);
            o_rear_left_speed       <= sat_spd(mix_rl);
            o_rear_right_speed      <= sat_spd(mix_rr);
            o_gimbal_roll_position  <= r_gr;
            o_gimbal_pitch_position <= r_gp;
            o_left_led_on           <= r_led;
            o_right_led_on          <= !r_led;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/qam_checker.sv
// Port-level checker for the attitude mixer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module qam_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_ready,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire signed [20:0] o_front_left_speed,
    input wire               o_left_led_on,
    input wire               o_right_led_on
);

    // a result waits until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

    // a stalled result keeps its front-left speed
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_front_left_speed))
        else $error("stalled result changed");

    // one item at a time: ready drops once an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // a new result only appears at the end of a sequence
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while the sequencer was idle");

    // LEDs are complementary while a result is valid
    a_led_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_led_on != o_right_led_on))
        else $error("LEDs not complementary");

endmodule

bind quadrotor_attitude_mixer_top qam_checker u_qam_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_front_left_speed (o_front_left_speed),
    .o_left_led_on      (o_left_led_on),
    .o_right_led_on     (o_right_led_on)
);

`default_nettype wire
